### rtl/core/assert_macros.svh
// assertion macros used by the checker file lkf_chk.sv
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LKF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("linear kalman filter check failed");

// next-cycle implication
`define LKF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("linear kalman filter check failed");

`endif

### rtl/core/lkf_pkg.sv
// shared constants, types and the step program of the kalman filter
// used by every module of the block; depends on nothing
package lkf_pkg;

    localparam int N_STATE   = 3;
    localparam int N_CTRL    = 1;
    localparam int N_MEAS    = 1;
    localparam int FRAC_BITS = 16;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 9;
    localparam int DIM_W  = 3;
    localparam int IDX_W  = 4;
    localparam int STEP_W = 4;
    localparam int TERM_W = 5;
    localparam int DIV_W  = DATA_W + FRAC_BITS;

    localparam logic [DATA_W-1:0] Q_ONE = DATA_W'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_PREDICT = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        SEL_A     = 3'd0,
        SEL_B     = 3'd1,
        SEL_H     = 3'd2,
        SEL_Q     = 3'd3,
        SEL_R     = 3'd4,
        SEL_P     = 3'd5,
        SEL_STATE = 3'd6,
        SEL_NONE  = 3'd7
    } t_sel;

    // memory regions, 16 words each; the first seven match the load targets
    localparam logic [3:0] RG_A    = 4'd0;
    localparam logic [3:0] RG_B    = 4'd1;
    localparam logic [3:0] RG_H    = 4'd2;
    localparam logic [3:0] RG_Q    = 4'd3;
    localparam logic [3:0] RG_R    = 4'd4;
    localparam logic [3:0] RG_P    = 4'd5;
    localparam logic [3:0] RG_S    = 4'd6;
    localparam logic [3:0] RG_T0   = 4'd7;   // A s, or P H'
    localparam logic [3:0] RG_T1   = 4'd8;   // B u, or H P H' + R and det
    localparam logic [3:0] RG_T2   = 4'd9;   // A P, adjugate, new P
    localparam logic [3:0] RG_T3   = 4'd10;  // A P A', or gain
    localparam logic [3:0] RG_SINV = 4'd11;
    localparam logic [3:0] RG_HS   = 4'd12;
    localparam logic [3:0] RG_INNO = 4'd13;
    localparam logic [3:0] RG_CORR = 4'd14;
    localparam logic [3:0] RG_IKH  = 4'd15;

    // operands that live in registers instead of the memory
    localparam logic [ADDR_W-1:0] V_ZERO = 9'h100;
    localparam logic [ADDR_W-1:0] V_ONE  = 9'h101;
    localparam logic [ADDR_W-1:0] V_U    = 9'h102;
    localparam logic [ADDR_W-1:0] V_Z    = 9'h104;

    typedef enum logic [2:0] {
        K_MM   = 3'd0,
        K_EW   = 3'd1,
        K_INV  = 3'd2,
        K_DIV  = 3'd3,
        K_DONE = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] a_base;
        logic [ADDR_W-1:0] b_base;
        logic [ADDR_W-1:0] d_base;
        logic [DIM_W-1:0]  r1;
        logic [DIM_W-1:0]  c1;
        logic [DIM_W-1:0]  c2;
        logic              bt;
        logic              x_ident;
        logic              y_zero;
        logic              y_neg;
        logic              need_ctrl;
        logic              ctrl_y;
    } t_step;

    // one product term sent from the controller to the datapath
    typedef struct packed {
        logic              vld;
        logic              dv;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] d;
        logic              neg;
        logic              last;
    } t_term;

    typedef struct packed {
        logic busy;
        logic wzero;
    } t_stat;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] d;
        logic              neg;
        logic              last;
        logic              jend;
    } t_inv;

    function automatic logic [ADDR_W-1:0] rg(input logic [3:0] region);
        return {1'b0, region, 4'd0};
    endfunction

    function automatic logic [ADDR_W-1:0] rgk(input logic [3:0] region, input int k);
        return {1'b0, region, 4'(k)};
    endfunction

    localparam logic [ADDR_W-1:0] A_DET = {1'b0, RG_T1, 4'd15};

    function automatic logic [4:0] elem_count(input logic [2:0] sel);
        logic [4:0] n;
        case (sel)
            SEL_A, SEL_Q, SEL_P: n = 5'(N_STATE * N_STATE);
            SEL_B:               n = 5'(N_STATE * N_CTRL);
            SEL_H:               n = 5'(N_MEAS * N_STATE);
            SEL_R:               n = 5'(N_MEAS * N_MEAS);
            SEL_STATE:           n = 5'(N_STATE);
            default:             n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic [DATA_W-1:0] r;
        if (x > 64'sh7FFFFFFF)
            r = 32'h7FFFFFFF;
        else if (x < -64'sh80000000)
            r = 32'h80000000;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

    function automatic t_step mm(input logic [3:0] a, input logic [3:0] b,
                                 input logic [3:0] d, input int r1, input int c1,
                                 input int c2, input logic bt, input logic need_ctrl);
        t_step s;
        s           = '0;
        s.kind      = K_MM;
        s.a_base    = rg(a);
        s.b_base    = (b == RG_B && need_ctrl) ? rg(b) : rg(b);
        s.d_base    = rg(d);
        s.r1        = DIM_W'(r1);
        s.c1        = DIM_W'(c1);
        s.c2        = DIM_W'(c2);
        s.bt        = bt;
        s.need_ctrl = need_ctrl;
        return s;
    endfunction

    function automatic t_step ew(input logic [ADDR_W-1:0] x, input logic [ADDR_W-1:0] y,
                                 input logic [3:0] d, input int r1, input int c2,
                                 input logic x_ident, input logic y_zero,
                                 input logic y_neg, input logic ctrl_y);
        t_step s;
        s         = '0;
        s.kind    = K_EW;
        s.a_base  = x;
        s.b_base  = y;
        s.d_base  = rg(d);
        s.r1      = DIM_W'(r1);
        s.c2      = DIM_W'(c2);
        s.x_ident = x_ident;
        s.y_zero  = y_zero;
        s.y_neg   = y_neg;
        s.ctrl_y  = ctrl_y;
        return s;
    endfunction

    function automatic t_step prog(input logic upd, input logic [STEP_W-1:0] step);
        t_step s;
        s      = '0;
        s.kind = K_DONE;
        if (!upd) begin
            case (step)
                4'd0: s = mm(RG_A, RG_S, RG_T0, N_STATE, N_STATE, 1, 1'b0, 1'b0);
                4'd1: begin
                    s = mm(RG_B, RG_S, RG_T1, N_STATE, N_CTRL, 1, 1'b0, 1'b1);
                    s.b_base = V_U;
                end
                4'd2: s = ew(rg(RG_T0), rg(RG_T1), RG_S, N_STATE, 1,
                             1'b0, 1'b0, 1'b0, 1'b1);
                4'd3: s = mm(RG_A, RG_P, RG_T2, N_STATE, N_STATE, N_STATE, 1'b0, 1'b0);
                4'd4: s = mm(RG_T2, RG_A, RG_T3, N_STATE, N_STATE, N_STATE, 1'b1, 1'b0);
                4'd5: s = ew(rg(RG_T3), rg(RG_Q), RG_P, N_STATE, N_STATE,
                             1'b0, 1'b0, 1'b0, 1'b0);
                default: s.kind = K_DONE;
            endcase
        end else begin
            case (step)
                4'd0:  s = mm(RG_P, RG_H, RG_T0, N_STATE, N_STATE, N_MEAS, 1'b1, 1'b0);
                4'd1:  s = mm(RG_H, RG_T0, RG_T1, N_MEAS, N_STATE, N_MEAS, 1'b0, 1'b0);
                4'd2:  s = ew(rg(RG_T1), rg(RG_R), RG_T1, N_MEAS, N_MEAS,
                              1'b0, 1'b0, 1'b0, 1'b0);
                4'd3:  s.kind = K_INV;
                4'd4: begin
                    s.kind   = K_DIV;
                    s.a_base = rg(RG_T2);
                    s.b_base = A_DET;
                    s.d_base = rg(RG_SINV);
                    s.r1     = DIM_W'(N_MEAS);
                    s.c2     = DIM_W'(N_MEAS);
                end
                4'd5:  s = mm(RG_T0, RG_SINV, RG_T3, N_STATE, N_MEAS, N_MEAS, 1'b0, 1'b0);
                4'd6:  s = mm(RG_H, RG_S, RG_HS, N_MEAS, N_STATE, 1, 1'b0, 1'b0);
                4'd7:  s = ew(V_Z, rg(RG_HS), RG_INNO, N_MEAS, 1,
                              1'b0, 1'b0, 1'b1, 1'b0);
                4'd8:  s = mm(RG_T3, RG_INNO, RG_CORR, N_STATE, N_MEAS, 1, 1'b0, 1'b0);
                4'd9:  s = ew(rg(RG_S), rg(RG_CORR), RG_S, N_STATE, 1,
                              1'b0, 1'b0, 1'b0, 1'b0);
                4'd10: s = mm(RG_T3, RG_H, RG_IKH, N_STATE, N_MEAS, N_STATE, 1'b0, 1'b0);
                4'd11: s = ew(V_ZERO, rg(RG_IKH), RG_IKH, N_STATE, N_STATE,
                              1'b1, 1'b0, 1'b1, 1'b0);
                4'd12: s = mm(RG_IKH, RG_P, RG_T2, N_STATE, N_STATE, N_STATE, 1'b0, 1'b0);
                4'd13: s = ew(rg(RG_T2), V_ZERO, RG_P, N_STATE, N_STATE,
                              1'b0, 1'b1, 1'b0, 1'b0);
                default: s.kind = K_DONE;
            endcase
        end
        return s;
    endfunction

    function automatic t_inv iv(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
                                input logic [ADDR_W-1:0] d, input logic neg,
                                input logic last, input logic jend);
        t_inv t;
        t.a    = a;
        t.b    = b;
        t.d    = d;
        t.neg  = neg;
        t.last = last;
        t.jend = jend;
        return t;
    endfunction

    // cross(p, q, r, s) = p*q - r*s into adjugate entry k, two terms
    function automatic t_inv cr(input int p, input int q, input int r, input int s,
                                input int k, input logic second);
        t_inv t;
        if (!second)
            t = iv(rgk(RG_T1, p), rgk(RG_T1, q), rgk(RG_T2, k), 1'b0, 1'b0, 1'b0);
        else
            t = iv(rgk(RG_T1, r), rgk(RG_T1, s), rgk(RG_T2, k), 1'b1, 1'b1, 1'b0);
        return t;
    endfunction

    // term list for adjugate and determinant of the innovation covariance
    function automatic t_inv inv_term(input logic [TERM_W-1:0] t);
        t_inv r;
        logic sec;
        r   = iv(V_ONE, V_ONE, A_DET, 1'b0, 1'b1, 1'b1);
        sec = t[0];
        if (N_MEAS == 1) begin
            case (t)
                5'd0:    r = iv(V_ONE, V_ONE, rgk(RG_T2, 0), 1'b0, 1'b1, 1'b0);
                default: r = iv(rgk(RG_T1, 0), V_ONE, A_DET, 1'b0, 1'b1, 1'b1);
            endcase
        end else if (N_MEAS == 2) begin
            case (t)
                5'd0:    r = iv(rgk(RG_T1, 3), V_ONE, rgk(RG_T2, 0), 1'b0, 1'b1, 1'b0);
                5'd1:    r = iv(rgk(RG_T1, 1), V_ONE, rgk(RG_T2, 1), 1'b1, 1'b1, 1'b0);
                5'd2:    r = iv(rgk(RG_T1, 2), V_ONE, rgk(RG_T2, 2), 1'b1, 1'b1, 1'b0);
                5'd3:    r = iv(rgk(RG_T1, 0), V_ONE, rgk(RG_T2, 3), 1'b0, 1'b1, 1'b0);
                5'd4:    r = iv(rgk(RG_T1, 0), rgk(RG_T1, 3), A_DET, 1'b0, 1'b0, 1'b0);
                default: r = iv(rgk(RG_T1, 1), rgk(RG_T1, 2), A_DET, 1'b1, 1'b1, 1'b1);
            endcase
        end else begin
            case (t[4:1])
                4'd0:    r = cr(4, 8, 5, 7, 0, sec);
                4'd1:    r = cr(2, 7, 1, 8, 1, sec);
                4'd2:    r = cr(1, 5, 2, 4, 2, sec);
                4'd3:    r = cr(5, 6, 3, 8, 3, sec);
                4'd4:    r = cr(0, 8, 2, 6, 4, sec);
                4'd5:    r = cr(2, 3, 0, 5, 5, sec);
                4'd6:    r = cr(3, 7, 4, 6, 6, sec);
                4'd7:    r = cr(1, 6, 0, 7, 7, sec);
                4'd8:    r = cr(0, 4, 1, 3, 8, sec);
                default: begin
                    case (t)
                        5'd18:   r = iv(rgk(RG_T1, 0), rgk(RG_T2, 0), A_DET,
                                        1'b0, 1'b0, 1'b0);
                        5'd19:   r = iv(rgk(RG_T1, 1), rgk(RG_T2, 3), A_DET,
                                        1'b0, 1'b0, 1'b0);
                        default: r = iv(rgk(RG_T1, 2), rgk(RG_T2, 6), A_DET,
                                        1'b0, 1'b1, 1'b1);
                    endcase
                end
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/core/lkf_div.sv
// restoring divider, one quotient bit a cycle: (a << FRAC_BITS) / b,
// truncated toward zero and saturated to 32 bits; depends on lkf_pkg
module lkf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lkf_pkg::DATA_W-1:0] i_num,
    input  logic [lkf_pkg::DATA_W-1:0] i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [lkf_pkg::DATA_W-1:0] o_quot
);
    import lkf_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                r_busy, r_fin, r_neg;
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W:0]     r_rem;
    logic [DIV_W-1:0]    r_q;
    logic [DATA_W-1:0]   r_den;
    logic [DATA_W:0]     n_rem_sh;
    logic                n_bit;
    logic [DATA_W-1:0]   mag_num, mag_den;

    assign mag_num  = i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
    assign mag_den  = i_den[DATA_W-1] ? (~i_den + 1'b1) : i_den;
    assign n_rem_sh = {r_rem[DATA_W-1:0], r_q[DIV_W-1]};
    assign n_bit    = (n_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {mag_num, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= mag_den;
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_bit ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
            r_q   <= {r_q[DIV_W-2:0], n_bit};
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_q > DIV_W'(64'h80000000))
                o_quot = 32'h80000000;
            else
                o_quot = ~r_q[DATA_W-1:0] + 1'b1;
        end else begin
            if (r_q > DIV_W'(64'h7FFFFFFF))
                o_quot = 32'h7FFFFFFF;
            else
                o_quot = r_q[DATA_W-1:0];
        end
    end

    assign o_busy = r_busy | r_fin;
    assign o_done = r_fin;

endmodule

### rtl/core/lkf_dp.sv
// datapath: operand memory, multiply-accumulate pipeline and divider
// driven term by term from lkf_ctrl; depends on lkf_pkg and lkf_div
module lkf_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ld_we,
    input  logic [lkf_pkg::ADDR_W-1:0]      i_ld_addr,
    input  logic [lkf_pkg::DATA_W-1:0]      i_load_value,
    input  logic                            i_cap,
    input  logic [lkf_pkg::DATA_W-1:0]      i_control_0,
    input  logic [lkf_pkg::DATA_W-1:0]      i_control_1,
    input  logic [lkf_pkg::DATA_W-1:0]      i_meas_0,
    input  logic [lkf_pkg::DATA_W-1:0]      i_meas_1,
    input  logic [lkf_pkg::DATA_W-1:0]      i_meas_2,
    input  lkf_pkg::t_term                  i_term,
    output lkf_pkg::t_stat                  o_stat,
    output logic [3:0][lkf_pkg::DATA_W-1:0] o_sv
);
    import lkf_pkg::*;

    logic [DATA_W-1:0] mem [256];
    logic [DATA_W-1:0] r_u [2];
    logic [DATA_W-1:0] r_z [3];
    logic [DATA_W-1:0] r_sv [4];

    logic [DATA_W-1:0] r_ra, r_rb;
    logic              r1_vld, r1_dv, r1_neg, r1_last;
    logic [ADDR_W-1:0] r1_d;
    logic signed [63:0] r2_prod;
    logic              r2_vld, r2_neg, r2_last;
    logic [ADDR_W-1:0] r2_d;
    logic signed [63:0] r_acc;
    logic              r3_wvld;
    logic [DATA_W-1:0] r3_val;
    logic [ADDR_W-1:0] r3_d, r_div_d;
    logic              r_wzero;

    logic signed [63:0] n_round, n_term, n_sum;
    logic              div_busy, div_done;
    logic [DATA_W-1:0] div_quot;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_data;
    logic              w_en;

    function automatic logic [DATA_W-1:0] vread(input logic [2:0] k,
                                                 input logic [DATA_W-1:0] u0,
                                                 input logic [DATA_W-1:0] u1,
                                                 input logic [DATA_W-1:0] z0,
                                                 input logic [DATA_W-1:0] z1,
                                                 input logic [DATA_W-1:0] z2);
        logic [DATA_W-1:0] v;
        case (k)
            3'd1:    v = Q_ONE;
            3'd2:    v = u0;
            3'd3:    v = u1;
            3'd4:    v = z0;
            3'd5:    v = z1;
            3'd6:    v = z2;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_u[0] <= i_control_0;
            r_u[1] <= i_control_1;
            r_z[0] <= i_meas_0;
            r_z[1] <= i_meas_1;
            r_z[2] <= i_meas_2;
        end
    end

    // operand fetch, registered read ports
    always_ff @(posedge i_clk) begin
        r_ra <= i_term.a[ADDR_W-1]
              ? vread(i_term.a[2:0], r_u[0], r_u[1], r_z[0], r_z[1], r_z[2])
              : mem[i_term.a[7:0]];
        r_rb <= i_term.b[ADDR_W-1]
              ? vread(i_term.b[2:0], r_u[0], r_u[1], r_z[0], r_z[1], r_z[2])
              : mem[i_term.b[7:0]];
    end

    assign w_en   = i_ld_we | r3_wvld;
    assign w_addr = i_ld_we ? i_ld_addr : r3_d;
    assign w_data = i_ld_we ? i_load_value : r3_val;

    always_ff @(posedge i_clk) begin
        if (w_en)
            mem[w_addr[7:0]] <= w_data;
    end

    // copy of the state vector for the result port
    always_ff @(posedge i_clk) begin
        if (w_en && w_addr[7:4] == RG_S && w_addr[3:0] < IDX_W'(N_STATE))
            r_sv[w_addr[1:0]] <= w_data;
    end

    always_comb begin
        for (int k = 0; k < 4; k++)
            o_sv[k] = (k < N_STATE) ? r_sv[k] : '0;
    end

    // round half up, then floor
    assign n_round = (r2_prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign n_term  = r2_neg ? -n_round : n_round;
    assign n_sum   = r_acc + n_term;

    always_ff @(posedge i_clk) begin
        r1_neg  <= i_term.neg;
        r1_last <= i_term.last;
        r1_d    <= i_term.d;
        r2_prod <= $signed(r_ra) * $signed(r_rb);
        r2_neg  <= r1_neg;
        r2_last <= r1_last;
        r2_d    <= r1_d;
        if (r1_dv)
            r_div_d <= r1_d;
        if (r2_vld && r2_last) begin
            r3_val <= sat32(n_sum);
            r3_d   <= r2_d;
        end else if (div_done) begin
            r3_val <= div_quot;
            r3_d   <= r_div_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r1_dv   <= 1'b0;
            r2_vld  <= 1'b0;
            r3_wvld <= 1'b0;
            r_acc   <= '0;
            r_wzero <= 1'b0;
        end else begin
            r1_vld  <= i_term.vld & ~i_term.dv;
            r1_dv   <= i_term.vld & i_term.dv;
            r2_vld  <= r1_vld;
            r3_wvld <= (r2_vld & r2_last) | div_done;
            if (r2_vld)
                r_acc <= r2_last ? 64'sd0 : n_sum;
            if (r3_wvld)
                r_wzero <= (r3_val == '0);
        end
    end

    lkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r1_dv),
        .i_num   (r_ra),
        .i_den   (r_rb),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_stat.busy  = r1_vld | r1_dv | r2_vld | r3_wvld | div_busy;
    assign o_stat.wzero = r_wzero;

endmodule

### rtl/core/lkf_ctrl.sv
// controller: walks the step program of predict and update, one product term per
// cycle between drain waits, and decodes load transactions; depends on lkf_pkg
module lkf_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [1:0]                 i_op,
    input  logic [2:0]                 i_matrix_select,
    input  logic [3:0]                 i_element_index,
    input  logic                       i_use_control,
    input  lkf_pkg::t_stat             i_stat,
    output logic                       o_idle,
    output logic                       o_ld_we,
    output logic [lkf_pkg::ADDR_W-1:0] o_ld_addr,
    output logic                       o_cap,
    output lkf_pkg::t_term             o_term,
    output logic                       o_done,
    output logic                       o_singular
);
    import lkf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_ISSUE = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state              r_state;
    logic                r_upd, r_ctrl, r_jend;
    logic [STEP_W-1:0]   r_step;
    logic [DIM_W-1:0]    r_i, r_j, r_l;
    logic [TERM_W-1:0]   r_t;
    t_step               cur;
    t_inv                inv;
    t_term               term;
    logic [IDX_W-1:0]    k_el, k_a, k_b;
    logic                ew_single, skip, step_end;

    function automatic logic [IDX_W-1:0] ix(input logic [DIM_W-1:0] x,
                                            input logic [DIM_W-1:0] y,
                                            input logic [DIM_W-1:0] z);
        logic [2*DIM_W:0] p;
        p = x * y + z;
        return p[IDX_W-1:0];
    endfunction

    assign cur       = prog(r_upd, r_step);
    assign inv       = inv_term(r_t);
    assign k_el      = ix(r_i, cur.c2, r_j);
    assign k_a       = ix(r_i, cur.c1, r_l);
    assign k_b       = cur.bt ? ix(r_j, cur.c1, r_l) : ix(r_l, cur.c2, r_j);
    assign ew_single = cur.y_zero | (cur.ctrl_y & ~r_ctrl);
    assign skip      = cur.need_ctrl & ~r_ctrl;
    assign step_end  = (r_j == cur.c2 - 1'b1) && (r_i == cur.r1 - 1'b1);

    always_comb begin
        term = '0;
        case (cur.kind)
            K_MM: begin
                term.a    = cur.a_base + ADDR_W'(k_a);
                term.b    = cur.b_base + ADDR_W'(k_b);
                term.d    = cur.d_base + ADDR_W'(k_el);
                term.last = (r_l == cur.c1 - 1'b1);
            end
            K_EW: begin
                term.d = cur.d_base + ADDR_W'(k_el);
                term.b = V_ONE;
                if (r_l == '0) begin
                    if (cur.x_ident)
                        term.a = (r_i == r_j) ? V_ONE : V_ZERO;
                    else
                        term.a = cur.a_base + ADDR_W'(k_el);
                    term.last = ew_single;
                end else begin
                    term.a    = cur.b_base + ADDR_W'(k_el);
                    term.neg  = cur.y_neg;
                    term.last = 1'b1;
                end
            end
            K_INV: begin
                term.a    = inv.a;
                term.b    = inv.b;
                term.d    = inv.d;
                term.neg  = inv.neg;
                term.last = inv.last;
            end
            K_DIV: begin
                term.dv   = 1'b1;
                term.a    = cur.a_base + ADDR_W'(k_el);
                term.b    = cur.b_base;
                term.d    = cur.d_base + ADDR_W'(k_el);
                term.last = 1'b1;
            end
            default: term = '0;
        endcase
        term.vld = (r_state == S_ISSUE);
    end

    assign o_term    = term;
    assign o_idle    = (r_state == S_IDLE);
    assign o_ld_we   = i_accept && i_op == OP_LOAD && i_matrix_select != SEL_NONE
                       && {1'b0, i_element_index} < elem_count(i_matrix_select);
    assign o_ld_addr = {2'b00, i_matrix_select, i_element_index};
    assign o_cap     = i_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_upd      <= 1'b0;
            r_ctrl     <= 1'b0;
            r_jend     <= 1'b0;
            r_step     <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_l        <= '0;
            r_t        <= '0;
            o_done     <= 1'b0;
            o_singular <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_accept && (i_op == OP_PREDICT || i_op == OP_UPDATE)) begin
                        r_upd   <= (i_op == OP_UPDATE);
                        r_ctrl  <= i_use_control && (N_CTRL > 0);
                        r_step  <= '0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_l <= '0;
                    r_t <= '0;
                    if (cur.kind == K_DONE) begin
                        o_done     <= 1'b1;
                        o_singular <= 1'b0;
                        r_state    <= S_IDLE;
                    end else if (cur.kind == K_DIV && i_stat.wzero) begin
                        // zero determinant: leave state and covariance as they are
                        o_done     <= 1'b1;
                        o_singular <= 1'b1;
                        r_state    <= S_IDLE;
                    end else if (skip) begin
                        r_step <= r_step + 1'b1;
                    end else begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_t <= r_t + 1'b1;
                    if (term.last) begin
                        r_l     <= '0;
                        r_jend  <= inv.jend;
                        r_state <= S_DRAIN;
                    end else begin
                        r_l <= r_l + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!i_stat.busy) begin
                        if (cur.kind == K_INV) begin
                            if (r_jend) begin
                                r_step  <= r_step + 1'b1;
                                r_state <= S_FETCH;
                            end else begin
                                r_state <= S_ISSUE;
                            end
                        end else if (step_end) begin
                            r_step  <= r_step + 1'b1;
                            r_state <= S_FETCH;
                        end else begin
                            if (r_j == cur.c2 - 1'b1) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/linear_kalman_filter_top.sv
// linear kalman filter, signed q16.16 with saturation
// top level: joins lkf_ctrl and lkf_dp and holds the result register; uses lkf_pkg
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  input    | i_in_valid / o_in_stall  | op, matrix_select, element_index, values
//  output   | o_out_valid / i_out_stall| state_0..state_3, singular
//
// a valid load is written in the cycle it is accepted. predict and update issue one
// product term a cycle and wait after each matrix element for the multiply
// pipeline to drain; each inverse entry goes through the serial divider. an update
// with a singular innovation stops before the division. one transaction is worked
// at a time; o_in_stall is high while it runs, while a result waits and during
// reset. reset is synchronous; the matrix stores are not cleared and hold garbage
// until loaded.
module linear_kalman_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_matrix_select,
    input  logic [3:0]  i_element_index,
    input  logic [31:0] i_load_value,
    input  logic        i_use_control,
    input  logic [31:0] i_control_0,
    input  logic [31:0] i_control_1,
    input  logic [31:0] i_meas_0,
    input  logic [31:0] i_meas_1,
    input  logic [31:0] i_meas_2,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_state_0,
    output logic [31:0] o_state_1,
    output logic [31:0] o_state_2,
    output logic [31:0] o_state_3,
    output logic        o_singular
);
    import lkf_pkg::*;

    logic                        accept, idle, ld_we, cap, done, sing;
    logic [ADDR_W-1:0]           ld_addr;
    t_term                       term;
    t_stat                       stat;
    logic [3:0][DATA_W-1:0]      sv;
    logic                        r_out_valid;

    assign o_in_stall = !i_rst_n || !idle || done || r_out_valid;
    assign accept     = i_in_valid && !o_in_stall;

    lkf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_op            (i_op),
        .i_matrix_select (i_matrix_select),
        .i_element_index (i_element_index),
        .i_use_control   (i_use_control),
        .i_stat          (stat),
        .o_idle          (idle),
        .o_ld_we         (ld_we),
        .o_ld_addr       (ld_addr),
        .o_cap           (cap),
        .o_term          (term),
        .o_done          (done),
        .o_singular      (sing)
    );

    lkf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ld_we      (ld_we),
        .i_ld_addr    (ld_addr),
        .i_load_value (i_load_value),
        .i_cap        (cap),
        .i_control_0  (i_control_0),
        .i_control_1  (i_control_1),
        .i_meas_0     (i_meas_0),
        .i_meas_1     (i_meas_1),
        .i_meas_2     (i_meas_2),
        .i_term       (term),
        .o_stat       (stat),
        .o_sv         (sv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            o_state_0  <= sv[0];
            o_state_1  <= sv[1];
            o_state_2  <= sv[2];
            o_state_3  <= sv[3];
            o_singular <= sing;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/lkf_chk.sv
// port-level checks for the kalman filter top, attached by bind
// uses assert_macros.svh and lkf_pkg
`include "assert_macros.svh"

module lkf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_op,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_state_0,
    input logic        o_singular
);
    import lkf_pkg::*;

    logic acc_load, acc_work;

    assign acc_load = i_in_valid && !o_in_stall && i_op == OP_LOAD;
    assign acc_work = i_in_valid && !o_in_stall && (i_op == OP_PREDICT || i_op == OP_UPDATE);

    // a held result keeps its value
    `LKF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
                     o_out_valid && $stable(o_state_0) && $stable(o_singular))
    // no transaction is taken while a result waits
    `LKF_ASSERT_NOW(a_no_take_pending, o_out_valid, o_in_stall)
    // a load finishes in its own cycle
    `LKF_ASSERT_NEXT(a_load_one_cycle, acc_load, !o_in_stall && !o_out_valid)
    // predict and update keep the input side stalled while they run
    `LKF_ASSERT_NEXT(a_work_busy, acc_work, o_in_stall && !o_out_valid)

endmodule

bind linear_kalman_filter_top lkf_chk u_lkf_chk (.*);

### sim/linear_kalman_filter_top_tb.sv
// self-checking testbench for linear_kalman_filter_top: bit-exact fixed-point filter
// predictor, bursty sender, stalling receiver; depends on lkf_pkg and the rtl
`timescale 1ns / 1ps

module linear_kalman_filter_top_tb;
    import lkf_pkg::*;

    typedef int t_mat[16];

    typedef struct {
        t_op      op;
        t_sel     sel;
        bit [3:0] idx;
        int       value;
        bit       use_ctrl;
        int       u0;
        int       u1;
        int       z0;
        int       z1;
        int       z2;
        bit       hold;   // wait until every state result is back before sending
    } t_item;

    typedef struct {
        int s0;
        int s1;
        int s2;
        int s3;
        bit singular;
    } t_est;

    localparam int ONE   = 1 << FRAC_BITS;
    localparam int WDOG  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = '0;
    logic [2:0]  i_matrix_select = '0;
    logic [3:0]  i_element_index = '0;
    logic [31:0] i_load_value = '0;
    logic        i_use_control = 1'b0;
    logic [31:0] i_control_0 = '0;
    logic [31:0] i_control_1 = '0;
    logic [31:0] i_meas_0 = '0;
    logic [31:0] i_meas_1 = '0;
    logic [31:0] i_meas_2 = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_state_0;
    logic [31:0] o_state_1;
    logic [31:0] o_state_2;
    logic [31:0] o_state_3;
    logic        o_singular;

    linear_kalman_filter_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter model state
    t_mat mat_a, mat_b, mat_h, mat_q, mat_r, mat_p, est;

    t_item pending[$];
    t_est  expected_est[$];
    int    errors = 0;
    bit    in_taken = 1'b0;
    int    idle_cycles = 0;

    function automatic longint qmul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic int clip(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return int'(x);
    endfunction

    function automatic void matmul(output t_mat r, input t_mat a, input t_mat b,
                                   input int r1, input int c1, input int c2, input bit bt);
        longint acc;
        r = '{default: 0};
        for (int i = 0; i < r1; i++)
            for (int j = 0; j < c2; j++) begin
                acc = 0;
                for (int l = 0; l < c1; l++)
                    acc += qmul(a[i*c1+l], bt ? b[j*c1+l] : b[l*c2+j]);
                r[i*c2+j] = clip(acc);
            end
    endfunction

    function automatic int minor2(int a, int b, int c, int d);
        return clip(qmul(a, b) - qmul(c, d));
    endfunction

    function automatic bit invert_innov(input t_mat s, output t_mat inv);
        t_mat adj;
        int   det;
        adj = '{default: 0};
        inv = '{default: 0};
        if (N_MEAS == 1) begin
            adj[0] = ONE;
            det    = s[0];
        end else if (N_MEAS == 2) begin
            adj[0] = s[3];
            adj[1] = clip(-longint'(s[1]));
            adj[2] = clip(-longint'(s[2]));
            adj[3] = s[0];
            det    = minor2(s[0], s[3], s[1], s[2]);
        end else begin
            adj[0] = minor2(s[4], s[8], s[5], s[7]);
            adj[1] = minor2(s[2], s[7], s[1], s[8]);
            adj[2] = minor2(s[1], s[5], s[2], s[4]);
            adj[3] = minor2(s[5], s[6], s[3], s[8]);
            adj[4] = minor2(s[0], s[8], s[2], s[6]);
            adj[5] = minor2(s[2], s[3], s[0], s[5]);
            adj[6] = minor2(s[3], s[7], s[4], s[6]);
            adj[7] = minor2(s[1], s[6], s[0], s[7]);
            adj[8] = minor2(s[0], s[4], s[1], s[3]);
            det = clip(qmul(s[0], adj[0]) + qmul(s[1], adj[3]) + qmul(s[2], adj[6]));
        end
        if (det == 0)
            return 1'b0;
        for (int i = 0; i < N_MEAS * N_MEAS; i++)
            inv[i] = clip((longint'(adj[i]) * ONE) / longint'(det));
        return 1'b1;
    endfunction

    function automatic void kf_predict(bit uc, int u0, int u1);
        t_mat ns, bu, u, ap;
        matmul(ns, mat_a, est, N_STATE, N_STATE, 1, 1'b0);
        if (uc && N_CTRL > 0) begin
            u = '{default: 0};
            u[0] = u0;
            u[1] = u1;
            matmul(bu, mat_b, u, N_STATE, N_CTRL, 1, 1'b0);
            for (int i = 0; i < N_STATE; i++)
                ns[i] = clip(longint'(ns[i]) + bu[i]);
        end
        for (int i = 0; i < N_STATE; i++)
            est[i] = ns[i];
        matmul(ap, mat_a, mat_p, N_STATE, N_STATE, N_STATE, 1'b0);
        matmul(ap, ap, mat_a, N_STATE, N_STATE, N_STATE, 1'b1);
        for (int i = 0; i < N_STATE * N_STATE; i++)
            mat_p[i] = clip(longint'(ap[i]) + mat_q[i]);
    endfunction

    function automatic bit kf_update(t_mat z);
        t_mat pht, s, sinv, gain, hs, innov, corr, ikh;
        matmul(pht, mat_p, mat_h, N_STATE, N_STATE, N_MEAS, 1'b1);
        matmul(s, mat_h, pht, N_MEAS, N_STATE, N_MEAS, 1'b0);
        for (int i = 0; i < N_MEAS * N_MEAS; i++)
            s[i] = clip(longint'(s[i]) + mat_r[i]);
        if (!invert_innov(s, sinv))
            return 1'b0;
        matmul(gain, pht, sinv, N_STATE, N_MEAS, N_MEAS, 1'b0);
        matmul(hs, mat_h, est, N_MEAS, N_STATE, 1, 1'b0);
        innov = '{default: 0};
        for (int i = 0; i < N_MEAS; i++)
            innov[i] = clip(longint'(z[i]) - hs[i]);
        matmul(corr, gain, innov, N_STATE, N_MEAS, 1, 1'b0);
        for (int i = 0; i < N_STATE; i++)
            est[i] = clip(longint'(est[i]) + corr[i]);
        matmul(ikh, gain, mat_h, N_STATE, N_MEAS, N_STATE, 1'b0);
        for (int i = 0; i < N_STATE; i++)
            for (int j = 0; j < N_STATE; j++)
                ikh[i*N_STATE+j] = clip(((i == j) ? longint'(ONE) : 64'sd0)
                                        - ikh[i*N_STATE+j]);
        matmul(mat_p, ikh, mat_p, N_STATE, N_STATE, N_STATE, 1'b0);
        return 1'b1;
    endfunction

    // returns 1 when the transaction produces a state result
    function automatic bit kf_step(input t_item it, output t_est r);
        t_mat z;
        bit   ok;
        int   cnt;
        r = '{default: 0};
        case (it.op)
            OP_LOAD: begin
                case (it.sel)
                    SEL_A, SEL_Q, SEL_P: cnt = N_STATE * N_STATE;
                    SEL_B:               cnt = N_STATE * N_CTRL;
                    SEL_H:               cnt = N_MEAS * N_STATE;
                    SEL_R:               cnt = N_MEAS * N_MEAS;
                    SEL_STATE:           cnt = N_STATE;
                    default:             cnt = 0;
                endcase
                if (int'(it.idx) < cnt)
                    case (it.sel)
                        SEL_A:     mat_a[it.idx] = it.value;
                        SEL_B:     mat_b[it.idx] = it.value;
                        SEL_H:     mat_h[it.idx] = it.value;
                        SEL_Q:     mat_q[it.idx] = it.value;
                        SEL_R:     mat_r[it.idx] = it.value;
                        SEL_P:     mat_p[it.idx] = it.value;
                        SEL_STATE: est[it.idx] = it.value;
                        default: ;
                    endcase
                return 1'b0;
            end
            OP_PREDICT: kf_predict(it.use_ctrl, it.u0, it.u1);
            OP_UPDATE: begin
                z = '{default: 0};
                z[0] = it.z0;
                z[1] = it.z1;
                z[2] = it.z2;
                ok = kf_update(z);
                r.singular = !ok;
            end
            default: return 1'b0;
        endcase
        r.s0 = (N_STATE > 0) ? est[0] : 0;
        r.s1 = (N_STATE > 1) ? est[1] : 0;
        r.s2 = (N_STATE > 2) ? est[2] : 0;
        r.s3 = (N_STATE > 3) ? est[3] : 0;
        return 1'b1;
    endfunction

    // mostly modest magnitudes so the filter stays out of saturation, some full range
    function automatic int rand_q();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
        if (k < 9)
            return $signed($urandom_range(0, ONE)) - ONE / 2;
        return $urandom;
    endfunction

    function automatic t_item blank();
        t_item it;
        it = '{op: OP_LOAD, sel: SEL_A, default: 0};
        return it;
    endfunction

    task automatic add_load(t_sel sel, int idx, int val);
        t_item it;
        it = blank();
        it.sel = sel;
        it.idx = 4'(idx);
        it.value = val;
        pending.push_back(it);
    endtask

    task automatic add_predict(bit uc, int u0, int u1);
        t_item it;
        it = blank();
        it.op = OP_PREDICT;
        it.use_ctrl = uc;
        it.u0 = u0;
        it.u1 = u1;
        it.value = $urandom;
        pending.push_back(it);
    endtask

    task automatic add_update(int z0, int z1, int z2);
        t_item it;
        it = blank();
        it.op = OP_UPDATE;
        it.z0 = z0;
        it.z1 = z1;
        it.z2 = z2;
        pending.push_back(it);
    endtask

    task automatic load_nominal();
        for (int i = 0; i < N_STATE; i++)
            for (int j = 0; j < N_STATE; j++) begin
                add_load(SEL_A, i*N_STATE+j, (i == j) ? ONE : ((j == i + 1) ? ONE / 10 : 0));
                add_load(SEL_Q, i*N_STATE+j, (i == j) ? 256 : 0);
                add_load(SEL_P, i*N_STATE+j, (i == j) ? ONE : 0);
            end
        for (int i = 0; i < N_STATE * N_CTRL; i++)
            add_load(SEL_B, i, (i == N_STATE * N_CTRL - 1) ? ONE / 10 : 0);
        for (int i = 0; i < N_MEAS * N_STATE; i++)
            add_load(SEL_H, i, (i % N_STATE == i / N_STATE) ? ONE : 0);
        for (int i = 0; i < N_MEAS * N_MEAS; i++)
            add_load(SEL_R, i, (i % N_MEAS == i / N_MEAS) ? ONE : 0);
        for (int i = 0; i < N_STATE; i++)
            add_load(SEL_STATE, i, 0);
    endtask

    // sender: bursts and gaps
    int burst_left = 4;
    int gap_left = 0;

    always @(negedge i_clk) begin
        bit    nv;
        t_item it;
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
                // hold the stalled transaction
            end else begin
                in_taken = 1'b0;
                nv = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() != 0 &&
                         !(pending[0].hold && expected_est.size() != 0)) begin
                    it = pending.pop_front();
                    nv = 1'b1;
                    i_op            <= it.op;
                    i_matrix_select <= it.sel;
                    i_element_index <= it.idx;
                    i_load_value    <= it.value;
                    i_use_control   <= it.use_ctrl;
                    i_control_0     <= it.u0;
                    i_control_1     <= it.u1;
                    i_meas_0        <= it.z0;
                    i_meas_1        <= it.z1;
                    i_meas_2        <= it.z2;
                    if (--burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                i_in_valid <= nv;
            end
        end
    end

    // receiver: stall mode is redrawn at random from four patterns
    int rx_cycle = 0;
    int rx_mode = 0;

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            1:       i_out_stall <= ($urandom_range(0, 1) == 1);
            2:       i_out_stall <= ((rx_cycle % 16) < 11);
            3:       i_out_stall <= ($urandom_range(0, 9) < 8);
            default: i_out_stall <= 1'b0;
        endcase
    end

    // input and output monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_item it;
        t_est  r;
        t_est  e;
        bit    act;
        act = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            it = blank();
            it.op       = t_op'(i_op);
            it.sel      = t_sel'(i_matrix_select);
            it.idx      = i_element_index;
            it.value    = i_load_value;
            it.use_ctrl = i_use_control;
            it.u0       = i_control_0;
            it.u1       = i_control_1;
            it.z0       = i_meas_0;
            it.z1       = i_meas_1;
            it.z2       = i_meas_2;
            if (kf_step(it, r))
                expected_est.push_back(r);
            in_taken = 1'b1;
            act = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            act = 1'b1;
            if (expected_est.size() == 0) begin
                $display("%0t: unexpected result transaction, state_0 %h", $time, o_state_0);
                errors++;
            end else begin
                e = expected_est.pop_front();
                if (o_state_0 !== e.s0 || o_state_1 !== e.s1 || o_state_2 !== e.s2 ||
                    o_state_3 !== e.s3 || o_singular !== e.singular) begin
                    $display("%0t: state mismatch expected %h %h %h %h sing %b", $time,
                             e.s0, e.s1, e.s2, e.s3, e.singular);
                    $display("%0t:                  actual %h %h %h %h sing %b", $time,
                             o_state_0, o_state_1, o_state_2, o_state_3, o_singular);
                    errors++;
                end
            end
        end
        if (act || !i_rst_n)
            idle_cycles = 0;
        else if (++idle_cycles >= WDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int k;
        t_item it;
        mat_a = '{default: 0};
        mat_b = '{default: 0};
        mat_h = '{default: 0};
        mat_q = '{default: 0};
        mat_r = '{default: 0};
        mat_p = '{default: 0};
        est   = '{default: 0};

        // every store is written before anything reads it
        load_nominal();

        // directed part
        add_predict(1'b0, 0, 0);
        add_predict(1'b1, 32'sh7FFFFFFF, 32'sh80000000);
        add_update(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        it = blank();
        it.op = OP_NONE;
        pending.push_back(it);
        add_load(SEL_NONE, 0, 32'sh12345678);
        add_load(SEL_A, 15, 32'sh7FFFFFFF);
        add_load(SEL_R, 15, 32'sh80000000);
        add_load(SEL_STATE, 0, 32'sh80000000);
        add_load(SEL_STATE, 1, 32'sh7FFFFFFF);
        add_predict(1'b0, 0, 0);
        // zero innovation covariance: update must be skipped
        for (int i = 0; i < N_MEAS * N_STATE; i++)
            add_load(SEL_H, i, 0);
        for (int i = 0; i < N_MEAS * N_MEAS; i++)
            add_load(SEL_R, i, 0);
        add_update(ONE, -ONE, 0);
        add_load(SEL_A, 0, 32'sh7FFFFFFF);
        add_predict(1'b1, -ONE, ONE);
        pending[pending.size()-1].hold = 1'b0;
        load_nominal();
        pending[0].hold = 1'b0;

        // random part
        for (int n = 0; n < 750; n++) begin
            k = $urandom_range(0, 99);
            if (n % 150 == 149) begin
                load_nominal();
                pending[pending.size()-1].hold = 1'b1;
            end else if (k < 35)
                add_load(t_sel'($urandom_range(0, 7)), $urandom_range(0, 15), rand_q());
            else if (k < 65)
                add_predict(1'($urandom_range(0, 1)), rand_q(), rand_q());
            else if (k < 97)
                add_update(rand_q(), rand_q(), rand_q());
            else begin
                it = blank();
                it.op = OP_NONE;
                it.sel = t_sel'($urandom_range(0, 7));
                it.idx = 4'($urandom_range(0, 15));
                it.value = $urandom;
                pending.push_back(it);
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending.size() == 0);
        @(posedge i_clk);
        wait (!i_in_valid || in_taken);
        wait (expected_est.size() == 0);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_est.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/lkf_pkg.sv
rtl/core/lkf_div.sv
rtl/core/lkf_dp.sv
rtl/core/lkf_ctrl.sv
rtl/core/linear_kalman_filter_top.sv
rtl/core/lkf_chk.sv
sim/linear_kalman_filter_top_tb.sv
